FILE: sv/sha256_pkg.sv
package sha256_pkg;

    localparam int ROUNDS = 64;
    localparam int QDEPTH = 4;

    // queue entry between the input port and the hash engine
    typedef struct packed {
        logic [31:0] data;
        logic [2:0]  nbytes;
        logic        last;
    } item_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PACK,
        S_PAD,
        S_ROUND,
        S_ADD,
        S_OUT
    } eng_state_t;

    function automatic logic [31:0] round_k(input logic [5:0] t);
        logic [31:0] k;
        case (t)
            6'd0: k = 32'h428A2F98; 6'd1: k = 32'h71374491;
            6'd2: k = 32'hB5C0FBCF; 6'd3: k = 32'hE9B5DBA5;
            6'd4: k = 32'h3956C25B; 6'd5: k = 32'h59F111F1;
            6'd6: k = 32'h923F82A4; 6'd7: k = 32'hAB1C5ED5;
            6'd8: k = 32'hD807AA98; 6'd9: k = 32'h12835B01;
            6'd10: k = 32'h243185BE; 6'd11: k = 32'h550C7DC3;
            6'd12: k = 32'h72BE5D74; 6'd13: k = 32'h80DEB1FE;
            6'd14: k = 32'h9BDC06A7; 6'd15: k = 32'hC19BF174;
            6'd16: k = 32'hE49B69C1; 6'd17: k = 32'hEFBE4786;
            6'd18: k = 32'h0FC19DC6; 6'd19: k = 32'h240CA1CC;
            6'd20: k = 32'h2DE92C6F; 6'd21: k = 32'h4A7484AA;
            6'd22: k = 32'h5CB0A9DC; 6'd23: k = 32'h76F988DA;
            6'd24: k = 32'h983E5152; 6'd25: k = 32'hA831C66D;
            6'd26: k = 32'hB00327C8; 6'd27: k = 32'hBF597FC7;
            6'd28: k = 32'hC6E00BF3; 6'd29: k = 32'hD5A79147;
            6'd30: k = 32'h06CA6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27B70A85; 6'd33: k = 32'h2E1B2138;
            6'd34: k = 32'h4D2C6DFC; 6'd35: k = 32'h53380D13;
            6'd36: k = 32'h650A7354; 6'd37: k = 32'h766A0ABB;
            6'd38: k = 32'h81C2C92E; 6'd39: k = 32'h92722C85;
            6'd40: k = 32'hA2BFE8A1; 6'd41: k = 32'hA81A664B;
            6'd42: k = 32'hC24B8B70; 6'd43: k = 32'hC76C51A3;
            6'd44: k = 32'hD192E819; 6'd45: k = 32'hD6990624;
            6'd46: k = 32'hF40E3585; 6'd47: k = 32'h106AA070;
            6'd48: k = 32'h19A4C116; 6'd49: k = 32'h1E376C08;
            6'd50: k = 32'h2748774C; 6'd51: k = 32'h34B0BCB5;
            6'd52: k = 32'h391C0CB3; 6'd53: k = 32'h4ED8AA4A;
            6'd54: k = 32'h5B9CCA4F; 6'd55: k = 32'h682E6FF3;
            6'd56: k = 32'h748F82EE; 6'd57: k = 32'h78A5636F;
            6'd58: k = 32'h84C87814; 6'd59: k = 32'h8CC70208;
            6'd60: k = 32'h90BEFFFA; 6'd61: k = 32'hA4506CEB;
            6'd62: k = 32'hBEF9A3F7; default: k = 32'hC67178F2;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] init_hash(input logic [2:0] i);
        logic [31:0] h;
        case (i)
            3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
        endcase
        return h;
    endfunction

endpackage

FILE: sv/sha256_front.sv
// Input queue: accepts items and holds them for the engine.
module sha256_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  sha256_pkg::item_t   in_item,
    output logic                q_valid,
    input  logic                q_take,
    output sha256_pkg::item_t   q_item
);
    sha256_pkg::item_t mem [sha256_pkg::QDEPTH];
    logic [1:0] wr_reg, rd_reg;
    logic [2:0] cnt_reg;
    logic       do_push, do_pop;

    assign full    = (cnt_reg == 3'(sha256_pkg::QDEPTH));
    assign q_valid = (cnt_reg != 3'd0);
    assign do_push = push && !full;
    assign do_pop  = q_take && q_valid;
    assign q_item  = mem[rd_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            // clamp counts above four
            mem[wr_reg] <= '{data: in_item.data,
                             nbytes: (in_item.nbytes > 3'd4) ? 3'd4 : in_item.nbytes,
                             last: in_item.last};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push) wr_reg <= wr_reg + 2'd1;
            if (do_pop)  rd_reg <= rd_reg + 2'd1;
            cnt_reg <= cnt_reg + 3'(do_push) - 3'(do_pop);
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 3'(sha256_pkg::QDEPTH))
        else $error("queue count overflow");
    assert property (@(posedge clk) disable iff (!rst_n) full |-> !do_push)
        else $error("push into full queue");
    assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> cnt_reg == $past(cnt_reg) + 3'd1)
        else $error("queue count miss");
endmodule

FILE: sv/sha256_engine.sv
// Packs bytes, pads, compresses and emits the digest.
module sha256_engine (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    output logic               q_take,
    input  sha256_pkg::item_t  q_item,
    output logic               empty,
    input  logic               pop,
    output logic [31:0]        digest_word,
    output logic [2:0]         word_index,
    output logic               digest_last
);
    sha256_pkg::eng_state_t st_reg, st_next;
    logic [31:0] hv_reg [8];
    logic [31:0] wv_reg [8];
    logic [31:0] w_reg  [16];
    logic [5:0]  fill_reg;
    logic [63:0] bits_reg;
    logic [5:0]  rnd_reg;
    logic [31:0] word_reg;
    logic [2:0]  left_reg;      // bytes of current item still to pack
    logic        last_reg;
    logic        padded_reg;    // 0x80 already placed
    logic        spill_reg;     // 0x80 landed past byte 55: rest of block is zero
    logic        len_done_reg;  // length bytes are in the block being hashed
    logic [2:0]  oidx_reg;

    // byte to place this cycle in PACK / PAD
    logic [7:0]  pad_byte;
    logic [7:0]  cur_byte;
    logic        full_blk;
    logic [31:0] ws, w2, w15, s0, s1, t1, t2, a, e;
    logic [3:0]  widx;

    always_comb
    begin
        if (!padded_reg)
            pad_byte = 8'h80;
        else if (fill_reg >= 6'd56 && !spill_reg)
            pad_byte = bits_reg[8'(7 - (fill_reg - 6'd56)) * 8 +: 8];
        else
            pad_byte = 8'h00;
    end
    assign cur_byte = (st_reg == sha256_pkg::S_PACK) ? word_reg[31:24] : pad_byte;
    assign full_blk = (fill_reg == 6'd63);

    // schedule and round
    assign widx = rnd_reg[3:0];
    assign w2   = w_reg[widx - 4'd2];
    assign w15  = w_reg[widx - 4'd15];
    assign s1   = {w2[16:0], w2[31:17]} ^ {w2[18:0], w2[31:19]} ^ (w2 >> 10);
    assign s0   = {w15[6:0], w15[31:7]} ^ {w15[17:0], w15[31:18]} ^ (w15 >> 3);
    assign ws   = (rnd_reg >= 6'd16) ? s1 + w_reg[widx - 4'd7] + s0 + w_reg[widx]
                                     : w_reg[widx];
    assign a    = wv_reg[0];
    assign e    = wv_reg[4];
    assign t1   = wv_reg[7] + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]})
                + ((e & wv_reg[5]) ^ (~e & wv_reg[6])) + sha256_pkg::round_k(rnd_reg) + ws;
    assign t2   = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]})
                + ((a & wv_reg[1]) ^ (a & wv_reg[2]) ^ (wv_reg[1] & wv_reg[2]));

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            sha256_pkg::S_IDLE:
                if (q_valid) st_next = sha256_pkg::S_PACK;
            sha256_pkg::S_PACK:
                if (left_reg != 3'd0)
                begin
                    if (full_blk) st_next = sha256_pkg::S_ROUND;
                end
                else if (last_reg) st_next = sha256_pkg::S_PAD;
                else st_next = sha256_pkg::S_IDLE;
            sha256_pkg::S_PAD:
                if (full_blk) st_next = sha256_pkg::S_ROUND;
            sha256_pkg::S_ROUND:
                if (rnd_reg == 6'(sha256_pkg::ROUNDS - 1)) st_next = sha256_pkg::S_ADD;
            sha256_pkg::S_ADD:
                if (left_reg != 3'd0) st_next = sha256_pkg::S_PACK;
                else if (!last_reg) st_next = sha256_pkg::S_IDLE;
                else if (len_done_reg) st_next = sha256_pkg::S_OUT;
                else st_next = sha256_pkg::S_PAD;
            sha256_pkg::S_OUT:
                if (pop && oidx_reg == 3'd7) st_next = sha256_pkg::S_IDLE;
            default: st_next = sha256_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        q_take      = (st_reg == sha256_pkg::S_IDLE);
        empty       = (st_reg != sha256_pkg::S_OUT);
        digest_word = hv_reg[oidx_reg];
        word_index  = oidx_reg;
        digest_last = (oidx_reg == 3'd7);
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == sha256_pkg::S_PACK && left_reg != 3'd0
            || st_reg == sha256_pkg::S_PAD)
        begin
            w_reg[fill_reg[5:2]][8'(3 - fill_reg[1:0]) * 8 +: 8] <= cur_byte;
        end
        if (st_reg == sha256_pkg::S_ROUND)
            w_reg[widx] <= ws;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg       <= sha256_pkg::S_IDLE;
            fill_reg     <= '0;
            bits_reg     <= '0;
            rnd_reg      <= '0;
            left_reg     <= '0;
            last_reg     <= 1'b0;
            padded_reg   <= 1'b0;
            spill_reg    <= 1'b0;
            len_done_reg <= 1'b0;
            oidx_reg     <= '0;
            word_reg     <= '0;
            for (int i = 0; i < 8; i++)
            begin
                hv_reg[i] <= sha256_pkg::init_hash(3'(i));
                wv_reg[i] <= '0;
            end
        end
        else
        begin
            st_reg <= st_next;
            case (st_reg)
                sha256_pkg::S_IDLE:
                    if (q_valid)
                    begin
                        word_reg <= q_item.data;
                        left_reg <= q_item.nbytes;
                        last_reg <= q_item.last;
                        bits_reg <= bits_reg + 64'({q_item.nbytes, 3'b000});
                    end
                sha256_pkg::S_PACK:
                    if (left_reg != 3'd0)
                    begin
                        word_reg <= {word_reg[23:0], 8'h00};
                        left_reg <= left_reg - 3'd1;
                        fill_reg <= fill_reg + 6'd1;
                        // block complete: load working vars for round 0
                        if (full_blk)
                            for (int i = 0; i < 8; i++) wv_reg[i] <= hv_reg[i];
                    end
                sha256_pkg::S_PAD:
                begin
                    padded_reg <= 1'b1;
                    fill_reg   <= fill_reg + 6'd1;
                    if (fill_reg == 6'd63)
                        spill_reg <= 1'b0;
                    else if (!padded_reg && fill_reg >= 6'd56)
                        spill_reg <= 1'b1;
                    if (full_blk)
                    begin
                        len_done_reg <= padded_reg && !spill_reg;
                        for (int i = 0; i < 8; i++) wv_reg[i] <= hv_reg[i];
                    end
                end
                sha256_pkg::S_ROUND:
                begin
                    wv_reg[7] <= wv_reg[6];
                    wv_reg[6] <= wv_reg[5];
                    wv_reg[5] <= wv_reg[4];
                    wv_reg[4] <= wv_reg[3] + t1;
                    wv_reg[3] <= wv_reg[2];
                    wv_reg[2] <= wv_reg[1];
                    wv_reg[1] <= wv_reg[0];
                    wv_reg[0] <= t1 + t2;
                    rnd_reg   <= rnd_reg + 6'd1;
                end
                sha256_pkg::S_ADD:
                begin
                    for (int i = 0; i < 8; i++) hv_reg[i] <= hv_reg[i] + wv_reg[i];
                    rnd_reg <= '0;
                end
                sha256_pkg::S_OUT:
                    if (pop)
                    begin
                        oidx_reg <= oidx_reg + 3'd1;
                        if (oidx_reg == 3'd7)
                        begin
                            for (int i = 0; i < 8; i++)
                            begin
                                hv_reg[i] <= sha256_pkg::init_hash(3'(i));
                                wv_reg[i] <= '0;
                            end
                            fill_reg     <= '0;
                            bits_reg     <= '0;
                            padded_reg   <= 1'b0;
                            spill_reg    <= 1'b0;
                            len_done_reg <= 1'b0;
                            last_reg     <= 1'b0;
                        end
                    end
                default: ;
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == sha256_pkg::S_OUT) |-> (last_reg && padded_reg))
        else $error("digest out before padding");
    assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg != sha256_pkg::S_ROUND && st_reg != sha256_pkg::S_ADD) |-> rnd_reg == 6'd0)
        else $error("round counter stray");
    assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == sha256_pkg::S_OUT && !pop) |=> $stable(oidx_reg))
        else $error("digest index moved without pop");
endmodule

FILE: sv/sha256_message_digest.sv
// SHA-256 engine. Push message words (big-endian, byte_count valid bytes from the top,
// last_word on the final word); after the last word the block pads the message, runs
// the remaining compressions and presents the eight digest words, index 0 first, to be
// popped. A four-entry input queue lets words arrive while the engine works. Rate is set
// by the single round unit and the byte packer: a full word is taken, packed one byte at
// a time and then closed, and each 64-byte block runs its 64 rounds and then the final add.
// Padding is placed byte by byte and costs one or two more blocks; the digest then waits
// for eight pops.
module sha256_message_digest (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [31:0] data_word,
    input  logic [2:0]  byte_count,
    input  logic        last_word,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        digest_last
);
    sha256_pkg::item_t in_item, q_item;
    logic              q_valid, q_take;

    assign in_item = '{data: data_word, nbytes: byte_count, last: last_word};

    sha256_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_item(in_item),
        .q_valid(q_valid), .q_take(q_take), .q_item(q_item)
    );

    sha256_engine u_engine (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_take(q_take), .q_item(q_item),
        .empty(empty), .pop(pop), .digest_word(digest_word), .word_index(word_index),
        .digest_last(digest_last)
    );
endmodule
